// ===== rtl/blake3_stream_hasher_top_assert.svh =====
// Assertion macros shared by the hasher RTL
`ifndef BLAKE3_STREAM_HASHER_TOP_ASSERT_SVH
`define BLAKE3_STREAM_HASHER_TOP_ASSERT_SVH
// condition must hold at every clock edge outside reset
`define B3SH_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// antecedent in a cycle implies consequent in the same cycle
`define B3SH_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`endif

// ===== rtl/b3sh_pkg.sv =====
// Types, constants and mixing function of the BLAKE3 stream hasher
`default_nettype none
package b3sh_pkg;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } b3sh_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_BLK_WAIT,
    S_CHUNK_WAIT,
    S_MERGE_CHK,
    S_MERGE_RD,
    S_MERGE_WAIT,
    S_FIN_CHK,
    S_FIN_WAIT,
    S_ROOT_WAIT,
    S_OUT
  } b3sh_state_e;

  localparam logic [3:0] FLAG_CHUNK_START = 4'd1;
  localparam logic [3:0] FLAG_CHUNK_END   = 4'd2;
  localparam logic [3:0] FLAG_PARENT      = 4'd4;
  localparam logic [3:0] FLAG_ROOT        = 4'd8;

  localparam logic [6:0] BLOCK_BYTES = 7'd64;
  localparam logic [4:0] LAST_BLOCK  = 5'd15;
  localparam logic [3:0] LAST_STEP   = 4'd13;

  localparam logic [255:0] IV = {
    32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
    32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
  };

  localparam int unsigned PERM [16] = '{2, 6, 3, 10, 7, 0, 4, 13, 1, 11, 12, 5, 9, 14, 15, 8};

  // one quarter mix, returns {a, b, c, d}
  function automatic logic [127:0] g_mix(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d,
                                         input logic [31:0] x, input logic [31:0] y);
    logic [31:0] a1, b1, c1, d1, t;
    a1 = a + b + x;
    t  = d ^ a1;
    d1 = {t[15:0], t[31:16]};
    c1 = c + d1;
    t  = b ^ c1;
    b1 = {t[11:0], t[31:12]};
    a1 = a1 + b1 + y;
    t  = d1 ^ a1;
    d1 = {t[7:0], t[31:8]};
    c1 = c1 + d1;
    t  = b1 ^ c1;
    b1 = {t[6:0], t[31:7]};
    return {a1, b1, c1, d1};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/blake3_stream_hasher_top.sv =====
// Top level of the BLAKE3 stream hasher
//
// Input channel (in_valid_i / in_stall_o): one beat carries data_word_i,
//   byte_count_i (0..8, counts above 8 taken as 8) and last_i. All beats but
//   the final one should carry 8 bytes; the final beat has last_i set.
// Output channel (out_valid_o / out_stall_i): the digest, 1..8 beats of up to
//   8 bytes, digest_last_o on the final beat. Unused byte lanes read zero.
// Config channel (cfg_valid_i / cfg_ready_o): digest length in bytes, 1..64,
//   reset 32; write only while no message is in flight.
// Sequencing: a beat is fetched from the queue, then inserted into the block.
//   A full 64-byte block is compressed once the next byte arrives: the back
//   end starts the compression unit (four quarter mixes per cycle over 14
//   steps) and waits for its result. A chunk end takes a compression plus one
//   per parent merge. The root needs one compression per stack entry plus one
//   after the last beat; digest beats then leave one per cycle unless stalled.
// A two-entry queue decouples the input from the back end, so the input is
//   stalled only when both entries are full. The output register holds its
//   beat while out_stall_i is high; the back end waits for it to drain.
// Reset clears all hashing state, the queue and the output; the digest
//   length returns to 32. After each digest the hashing state clears itself.
`default_nettype none
module blake3_stream_hasher_top #(
  parameter int unsigned STACK_DEPTH = 54
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] data_word_i,
  input  wire logic [3:0]  byte_count_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      digest_word_o,
  output logic [3:0]       digest_valid_bytes_o,
  output logic             digest_last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [6:0]  cfg_data_i
);
  import b3sh_pkg::*;

  logic       q_valid, q_pop;
  b3sh_item_t q_item;
  logic [6:0] digest_bytes_q;

  // config register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digest_bytes_q <= 7'd32;
    end else if (cfg_valid_i && cfg_ready_o) begin
      digest_bytes_q <= cfg_data_i;
    end
  end

  b3sh_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .data_word_i, .byte_count_i, .last_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  b3sh_engine #(.STACK_DEPTH(STACK_DEPTH)) u_engine (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .digest_bytes_i(digest_bytes_q),
    .out_valid_o, .out_stall_i, .digest_word_o, .digest_valid_bytes_o, .digest_last_o
  );

endmodule
`default_nettype wire

// ===== rtl/b3sh_compress.sv =====
// Iterative compression unit: four quarter mixes per cycle, 14 steps
`default_nettype none
module b3sh_compress (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [255:0] cv_i,
  input  wire logic [511:0] msg_i,
  input  wire logic [53:0]  ctr_i,
  input  wire logic [6:0]   len_i,
  input  wire logic [3:0]   flags_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [511:0]      hash_o
);
  import b3sh_pkg::*;

  logic [15:0][31:0] v_q, v_d, m_q, m_d;
  logic [7:0][31:0]  cv_q;
  logic [3:0]        step_q;
  logic              busy_q, done_q;

  always_comb begin
    v_d = v_q;
    m_d = m_q;
    if (!step_q[0]) begin
      {v_d[0], v_d[4], v_d[8],  v_d[12]} = g_mix(v_q[0], v_q[4], v_q[8],  v_q[12], m_q[0], m_q[1]);
      {v_d[1], v_d[5], v_d[9],  v_d[13]} = g_mix(v_q[1], v_q[5], v_q[9],  v_q[13], m_q[2], m_q[3]);
      {v_d[2], v_d[6], v_d[10], v_d[14]} = g_mix(v_q[2], v_q[6], v_q[10], v_q[14], m_q[4], m_q[5]);
      {v_d[3], v_d[7], v_d[11], v_d[15]} = g_mix(v_q[3], v_q[7], v_q[11], v_q[15], m_q[6], m_q[7]);
    end else begin
      {v_d[0], v_d[5], v_d[10], v_d[15]} = g_mix(v_q[0], v_q[5], v_q[10], v_q[15], m_q[8], m_q[9]);
      {v_d[1], v_d[6], v_d[11], v_d[12]} = g_mix(v_q[1], v_q[6], v_q[11], v_q[12],
                                                 m_q[10], m_q[11]);
      {v_d[2], v_d[7], v_d[8],  v_d[13]} = g_mix(v_q[2], v_q[7], v_q[8],  v_q[13],
                                                 m_q[12], m_q[13]);
      {v_d[3], v_d[4], v_d[9],  v_d[14]} = g_mix(v_q[3], v_q[4], v_q[9],  v_q[14],
                                                 m_q[14], m_q[15]);
      for (int i = 0; i < 16; i++) m_d[i] = m_q[4'(PERM[i])];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 4'd1;
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q  <= {{28'd0, flags_i}, 25'd0, len_i,
               {10'd0, ctr_i}, IV[127:0], cv_i};
      m_q  <= msg_i;
      cv_q <= cv_i;
    end else if (busy_q) begin
      v_q <= v_d;
      m_q <= m_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hash_o[32*i +: 32]       = v_q[i] ^ v_q[i+8];
      hash_o[256 + 32*i +: 32] = v_q[i+8] ^ cv_q[i];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== rtl/b3sh_engine.sv =====
// Back end: block filling, chunk and parent sequencing, CV stack, digest output
`default_nettype none
module b3sh_engine #(
  parameter int unsigned STACK_DEPTH = 54
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  wire b3sh_pkg::b3sh_item_t q_item_i,
  output logic                     q_pop_o,
  input  wire logic [6:0]          digest_bytes_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [63:0]              digest_word_o,
  output logic [3:0]               digest_valid_bytes_o,
  output logic                     digest_last_o
);
  import b3sh_pkg::*;

  localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  b3sh_state_e state_q, state_d;

  logic [511:0]   buf_q;
  logic [6:0]     fill_q;
  logic [4:0]     blk_q;
  logic [255:0]   cv_q, ncv_q;
  logic [53:0]    cnt_q, tot_q;
  logic [SPW-1:0] sp_q, sp_m1;
  logic [63:0]    word_q;
  logic [3:0]     rem_q;
  logic           last_q;
  logic [3:0]     fl_q;
  logic [511:0]   dig_q;
  logic [2:0]     widx_q;

  logic [255:0]   mem [STACK_DEPTH];
  logic [255:0]   rd_q;
  logic [AW-1:0]  ra, wa;
  logic           mem_re, mem_we;

  logic           ov_q, out_free;
  logic [63:0]    ow_q;
  logic [3:0]     ob_q;
  logic           ol_q;

  logic           cmp_start, cmp_busy, cmp_done;
  logic [255:0]   cmp_cv;
  logic [511:0]   cmp_msg, cmp_out;
  logic [53:0]    cmp_ctr;
  logic [6:0]     cmp_len, space;
  logic [3:0]     cmp_flags, k;
  logic           need_comp, stack_full;

  logic [511:0]   buf_ins;
  logic [6:0]     dclamp, drem;
  logic [3:0]     wvalid;
  logic [63:0]    wword;
  logic           wlast;

  b3sh_compress u_cmp (
    .clk_i, .rst_ni,
    .start_i(cmp_start), .cv_i(cmp_cv), .msg_i(cmp_msg), .ctr_i(cmp_ctr),
    .len_i(cmp_len), .flags_i(cmp_flags),
    .busy_o(cmp_busy), .done_o(cmp_done), .hash_o(cmp_out)
  );

  assign space      = BLOCK_BYTES - fill_q;
  assign k          = ({3'd0, rem_q} > space) ? space[3:0] : rem_q;
  assign need_comp  = (rem_q != 4'd0) && (fill_q == BLOCK_BYTES);
  assign sp_m1      = sp_q - 1'b1;
  assign stack_full = (sp_q >= SPW'(STACK_DEPTH));
  assign out_free   = !ov_q || !out_stall_i;

  // byte lane insert of the pending word at the fill point
  always_comb begin
    logic [6:0] rel;
    for (int j = 0; j < 64; j++) begin
      rel = 7'(j) - fill_q;
      buf_ins[8*j +: 8] = buf_q[8*j +: 8];
      if ((7'(j) >= fill_q) && (rel < {3'd0, k})) buf_ins[8*j +: 8] = word_q[8*rel[2:0] +: 8];
    end
  end

  // digest word selection
  always_comb begin
    dclamp = (digest_bytes_i == 7'd0) ? 7'd1 :
             (digest_bytes_i > 7'd64) ? 7'd64 : digest_bytes_i;
    drem   = dclamp - {1'b0, widx_q, 3'd0};
    wvalid = (drem > 7'd8) ? 4'd8 : drem[3:0];
    wlast  = (drem <= 7'd8);
    wword  = dig_q[64*widx_q +: 64];
    for (int b = 0; b < 8; b++) if (4'(b) >= wvalid) wword[8*b +: 8] = 8'd0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:       if (q_valid_i) state_d = S_FILL;
      S_FILL: begin
        if (need_comp) state_d = (blk_q >= LAST_BLOCK) ? S_CHUNK_WAIT : S_BLK_WAIT;
        else if (rem_q == k) state_d = last_q ? S_FIN_CHK : S_IDLE;
      end
      S_BLK_WAIT:   if (cmp_done) state_d = S_FILL;
      S_CHUNK_WAIT: if (cmp_done) state_d = S_MERGE_CHK;
      S_MERGE_CHK:  state_d = (!tot_q[0] && sp_q != '0) ? S_MERGE_RD : S_FILL;
      S_MERGE_RD:   state_d = S_MERGE_WAIT;
      S_MERGE_WAIT: if (cmp_done) state_d = S_MERGE_CHK;
      S_FIN_CHK:    state_d = (sp_q != '0) ? S_FIN_WAIT : S_ROOT_WAIT;
      S_FIN_WAIT:   if (cmp_done) state_d = S_FIN_CHK;
      S_ROOT_WAIT:  if (cmp_done) state_d = S_OUT;
      S_OUT:        if (out_free && wlast) state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop_o   = 1'b0;
    cmp_start = 1'b0;
    cmp_cv    = cv_q;
    cmp_msg   = buf_q;
    cmp_ctr   = cnt_q;
    cmp_len   = BLOCK_BYTES;
    cmp_flags = ((blk_q == '0) ? FLAG_CHUNK_START : 4'd0) |
                ((blk_q >= LAST_BLOCK) ? FLAG_CHUNK_END : 4'd0);
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    ra        = sp_m1[AW-1:0];
    wa        = stack_full ? AW'(STACK_DEPTH - 1) : sp_q[AW-1:0];
    case (state_q)
      S_IDLE:      q_pop_o = q_valid_i;
      S_FILL:      cmp_start = need_comp;
      S_MERGE_CHK: begin
        mem_re = !tot_q[0] && sp_q != '0;
        mem_we = !mem_re;
      end
      S_MERGE_RD: begin
        cmp_start = 1'b1;
        cmp_cv    = IV;
        cmp_msg   = {ncv_q, rd_q};
        cmp_ctr   = '0;
        cmp_flags = FLAG_PARENT;
      end
      S_FIN_CHK: begin
        cmp_start = 1'b1;
        cmp_len   = fill_q;
        cmp_flags = fl_q | ((sp_q == '0) ? FLAG_ROOT : 4'd0);
        mem_re    = sp_q != '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wa] <= ncv_q;
    if (mem_re) rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      buf_q   <= '0;
      fill_q  <= '0;
      blk_q   <= '0;
      cv_q    <= IV;
      cnt_q   <= '0;
      sp_q    <= '0;
      rem_q   <= '0;
      last_q  <= 1'b0;
      fl_q    <= '0;
      widx_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q != S_OUT && !out_stall_i) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: if (q_valid_i) begin
          word_q <= q_item_i.word;
          rem_q  <= q_item_i.nbytes;
          last_q <= q_item_i.last;
        end
        S_FILL: if (!need_comp) begin
          buf_q  <= buf_ins;
          fill_q <= fill_q + {3'd0, k};
          rem_q  <= rem_q - k;
          word_q <= word_q >> {k, 3'd0};
          fl_q   <= ((blk_q == '0) ? FLAG_CHUNK_START : 4'd0) | FLAG_CHUNK_END;
        end
        S_BLK_WAIT: if (cmp_done) begin
          cv_q   <= cmp_out[255:0];
          blk_q  <= blk_q + 5'd1;
          buf_q  <= '0;
          fill_q <= '0;
        end
        S_CHUNK_WAIT: if (cmp_done) begin
          ncv_q <= cmp_out[255:0];
          tot_q <= cnt_q + 54'd1;
        end
        S_MERGE_CHK: begin
          if (!tot_q[0] && sp_q != '0) begin
            sp_q <= sp_m1;
          end else begin
            if (!stack_full) sp_q <= sp_q + 1'b1;
            cnt_q  <= cnt_q + 54'd1;
            buf_q  <= '0;
            fill_q <= '0;
            blk_q  <= '0;
            cv_q   <= IV;
          end
        end
        S_MERGE_WAIT: if (cmp_done) begin
          ncv_q <= cmp_out[255:0];
          tot_q <= tot_q >> 1;
        end
        S_FIN_WAIT: if (cmp_done) begin
          buf_q  <= {cmp_out[255:0], rd_q};
          cv_q   <= IV;
          fill_q <= BLOCK_BYTES;
          cnt_q  <= '0;
          fl_q   <= FLAG_PARENT;
          sp_q   <= sp_m1;
        end
        S_ROOT_WAIT: if (cmp_done) begin
          dig_q  <= cmp_out;
          widx_q <= '0;
        end
        S_OUT: if (out_free) begin
          ov_q   <= 1'b1;
          ow_q   <= wword;
          ob_q   <= wvalid;
          ol_q   <= wlast;
          widx_q <= widx_q + 3'd1;
          if (wlast) begin
            buf_q  <= '0;
            fill_q <= '0;
            blk_q  <= '0;
            cv_q   <= IV;
            cnt_q  <= '0;
            sp_q   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o          = ov_q;
  assign digest_word_o        = ow_q;
  assign digest_valid_bytes_o = ob_q;
  assign digest_last_o        = ol_q;

  `include "blake3_stream_hasher_top_assert.svh"
  `B3SH_ASSERT_ALWAYS(a_sp_range, sp_q <= SPW'(STACK_DEPTH), "stack pointer past depth")
  `B3SH_ASSERT_ALWAYS(a_fill_range, fill_q <= BLOCK_BYTES, "block fill past 64")
  `B3SH_ASSERT_IMPLY(a_start_idle, cmp_start, !cmp_busy, "compression started while busy")

endmodule
`default_nettype wire

// ===== rtl/b3sh_front.sv =====
// Front end: input beat acceptance, byte count clamp, two-entry queue
`default_nettype none
module b3sh_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [63:0]          data_word_i,
  input  wire logic [3:0]           byte_count_i,
  input  wire logic                 last_i,
  output logic                      q_valid_o,
  output b3sh_pkg::b3sh_item_t      q_item_o,
  input  wire logic                 q_pop_i
);
  import b3sh_pkg::*;

  b3sh_item_t ent_q [2];
  b3sh_item_t item;
  logic       wp_q, rp_q, push;
  logic [1:0] cnt_q;

  assign item.word   = data_word_i;
  assign item.nbytes = (byte_count_i > 4'd8) ? 4'd8 : byte_count_i;
  assign item.last   = last_i;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wp_q] <= item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (q_pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule
`default_nettype wire
